FILE: rtl/fjsp_pkg.sv
// Package for the flat JSON string dictionary parser.
// Holds the port payload types, byte classes, parse phases and character codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fjsp_pkg;

  // Input transfer: one document byte and its last-byte flag
  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_item_t;

  // Result transfer: decoded character, tags and status
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       is_value;
    logic       field_end;
    logic [1:0] status;
  } result_t;

  // Status codes carried in result_t.status
  localparam logic [1:0] STATUS_RUN   = 2'd0;
  localparam logic [1:0] STATUS_DONE  = 2'd1;
  localparam logic [1:0] STATUS_ERROR = 2'd2;

  // Byte classes produced by the front end
  typedef enum logic [2:0] {
    CLS_OTHER  = 3'd0,
    CLS_SPACE  = 3'd1,
    CLS_QUOTE  = 3'd2,
    CLS_BSLASH = 3'd3,
    CLS_LET_T  = 3'd4,
    CLS_LET_N  = 3'd5
  } cls_t;

  // Classified byte held in the queue between front and back
  typedef struct packed {
    cls_t       cls;
    logic [7:0] raw;
    logic       last;
  } tok_t;

  // Parse phases; codes 6 and 7 behave as PH_WAIT
  typedef enum logic [2:0] {
    PH_OPEN  = 3'd0,
    PH_KEY   = 3'd1,
    PH_COLON = 3'd2,
    PH_VALUE = 3'd3,
    PH_SEP   = 3'd4,
    PH_WAIT  = 3'd5
  } phase_t;

  // Character codes
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LET_T  = 8'h74;
  localparam logic [7:0] CH_LET_N  = 8'h6E;
  localparam logic [7:0] CH_OPEN   = 8'h7B;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CLOSE  = 8'h7D;

endpackage

`default_nettype wire

FILE: rtl/fjsp_front.sv
// Front end: classifies each accepted byte and queues it for the parser.
// Depends on fjsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fjsp_front
  import fjsp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire in_item_t item,
  input  wire logic     push,
  output logic          full,
  output tok_t          tok,
  output logic          tok_avail,
  input  wire logic     tok_take
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tok_t             q [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  tok_t             tok_in;
  logic             wr_en;
  logic             rd_en;

  // Classify the incoming byte
  always_comb begin
    tok_in.raw  = item.in_byte;
    tok_in.last = item.last_byte;
    case (item.in_byte)
      CH_SPACE:  tok_in.cls = CLS_SPACE;
      CH_QUOTE:  tok_in.cls = CLS_QUOTE;
      CH_BSLASH: tok_in.cls = CLS_BSLASH;
      CH_LET_T:  tok_in.cls = CLS_LET_T;
      CH_LET_N:  tok_in.cls = CLS_LET_N;
      default:   tok_in.cls = CLS_OTHER;
    endcase
  end

  assign full      = (count == CNT_W'(DEPTH));
  assign tok_avail = (count != '0);
  assign tok       = q[rd_ptr];
  assign wr_en     = push && !full;
  assign rd_en     = tok_take && tok_avail;

  // Store the classified byte
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q[wr_ptr] <= tok_in;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fjsp_back.sv
// Back end: grammar state machine, escape decoding and a two-entry result queue.
// Depends on fjsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fjsp_back
  import fjsp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire tok_t tok,
  input  wire logic tok_avail,
  output logic      tok_take,
  output result_t   result,
  output logic      empty,
  input  wire logic pop
);

  localparam int OUT_DEPTH = 2;

  // Parser state
  phase_t     phase;
  logic       in_string;
  logic       escape_pending;
  logic [1:0] token_length;
  logic [7:0] token_char;

  phase_t     phase_next;
  logic       in_string_next;
  logic       escape_pending_next;
  logic [1:0] token_length_next;
  logic [7:0] token_char_next;

  // Decode intermediates
  logic       wait_ph;
  logic       field;
  logic       add;
  logic [7:0] dec_char;
  logic       tok_done;
  logic       single;
  logic       esc_err;
  logic       str_upd;
  logic       esc_upd;
  logic [1:0] tlen_upd;
  logic [7:0] tchar_upd;
  logic       is_open;
  logic       is_colon;
  logic       is_comma;
  logic       is_close;
  phase_t     ph_upd;
  logic       tok_err;
  logic       done;
  logic       err_any;
  logic       report;

  // Result generation
  logic       res_valid;
  result_t    res;

  // Result queue
  result_t    oq [OUT_DEPTH];
  logic       owr_ptr;
  logic       ord_ptr;
  logic [1:0] ocount;
  logic       out_wr;
  logic       out_rd;

  assign empty    = (ocount == 2'd0);
  assign out_rd   = pop && !empty;
  assign tok_take = tok_avail && ((ocount != 2'(OUT_DEPTH)) || out_rd);
  assign out_wr   = tok_take && res_valid;
  assign result   = oq[ord_ptr];

  // Classify the phase
  always_comb begin
    wait_ph = 1'b0;
    field   = 1'b0;
    unique case (phase) inside
      PH_OPEN, PH_COLON, PH_SEP: field = 1'b0;
      PH_KEY, PH_VALUE:          field = 1'b1;
      default:                   wait_ph = 1'b1;
    endcase
  end

  // Decode the byte against the string and escape state
  always_comb begin
    add       = 1'b0;
    dec_char  = tok.raw;
    tok_done  = 1'b0;
    single    = 1'b0;
    esc_err   = 1'b0;
    str_upd   = in_string;
    esc_upd   = escape_pending;
    tlen_upd  = token_length;
    tchar_upd = token_char;
    if (in_string) begin
      if (escape_pending) begin
        esc_upd = 1'b0;
        case (tok.cls)
          CLS_LET_T: begin
            add      = 1'b1;
            dec_char = CH_TAB;
          end
          CLS_LET_N: begin
            add      = 1'b1;
            dec_char = CH_NL;
          end
          CLS_BSLASH, CLS_QUOTE: add = 1'b1;
          default: esc_err = 1'b1;
        endcase
      end else if (tok.cls == CLS_QUOTE) begin
        str_upd  = 1'b0;
        tok_done = 1'b1;
      end else if (tok.cls == CLS_BSLASH) begin
        esc_upd = 1'b1;
      end else begin
        add = 1'b1;
      end
      // Collect structural token characters, saturating the length at two
      if (add && !field) begin
        if (token_length == 2'd0) begin
          tchar_upd = dec_char;
        end
        if (token_length != 2'd2) begin
          tlen_upd = token_length + 1'b1;
        end
      end
    end else if (tok.cls == CLS_SPACE) begin
      str_upd = in_string;
    end else if (tok.cls == CLS_QUOTE) begin
      str_upd   = 1'b1;
      esc_upd   = 1'b0;
      tlen_upd  = 2'd0;
      tchar_upd = 8'd0;
    end else begin
      tlen_upd  = 2'd1;
      tchar_upd = tok.raw;
      tok_done  = 1'b1;
      single    = 1'b1;
    end
  end

  assign is_open  = (tlen_upd == 2'd1) && (tchar_upd == CH_OPEN);
  assign is_colon = (tlen_upd == 2'd1) && (tchar_upd == CH_COLON);
  assign is_comma = (tlen_upd == 2'd1) && (tchar_upd == CH_COMMA);
  assign is_close = (tlen_upd == 2'd1) && (tchar_upd == CH_CLOSE);

  // Check the finished token against the grammar
  always_comb begin
    ph_upd  = phase;
    tok_err = 1'b0;
    done    = 1'b0;
    if (tok_done) begin
      unique case (phase)
        PH_OPEN: begin
          if (is_open) ph_upd = PH_KEY;
          else tok_err = 1'b1;
        end
        PH_KEY:   ph_upd = PH_COLON;
        PH_VALUE: ph_upd = PH_SEP;
        PH_COLON: begin
          if (is_colon) ph_upd = PH_VALUE;
          else tok_err = 1'b1;
        end
        default: begin
          if (is_comma) ph_upd = PH_KEY;
          else if (is_close) done = 1'b1;
          else tok_err = 1'b1;
        end
      endcase
    end
    err_any = esc_err || tok_err || (tok.last && !done);
    report  = err_any || done;
  end

  // Next state
  always_comb begin
    phase_next          = phase;
    in_string_next      = in_string;
    escape_pending_next = escape_pending;
    token_length_next   = token_length;
    token_char_next     = token_char;
    if (wait_ph || (report && tok.last)) begin
      // Start over after the last byte; otherwise hold while waiting
      if (tok.last) begin
        phase_next          = PH_OPEN;
        in_string_next      = 1'b0;
        escape_pending_next = 1'b0;
        token_length_next   = 2'd0;
        token_char_next     = 8'd0;
      end
    end else if (report) begin
      phase_next          = PH_WAIT;
      in_string_next      = 1'b0;
      escape_pending_next = 1'b0;
      token_length_next   = tlen_upd;
      token_char_next     = tchar_upd;
    end else begin
      phase_next          = ph_upd;
      in_string_next      = str_upd;
      escape_pending_next = esc_upd;
      token_length_next   = tlen_upd;
      token_char_next     = tchar_upd;
    end
  end

  // Outputs of the state machine: one result or none per byte
  always_comb begin
    res_valid      = 1'b0;
    res.out_byte   = 8'd0;
    res.byte_valid = 1'b0;
    res.is_value   = 1'b0;
    res.field_end  = 1'b0;
    res.status     = STATUS_RUN;
    if (!wait_ph) begin
      if (report) begin
        res_valid  = 1'b1;
        res.status = err_any ? STATUS_ERROR : STATUS_DONE;
      end else if (add && field) begin
        res_valid      = 1'b1;
        res.out_byte   = dec_char;
        res.byte_valid = 1'b1;
        res.is_value   = (phase == PH_VALUE);
      end else if (tok_done && field) begin
        res_valid      = 1'b1;
        res.out_byte   = single ? tok.raw : 8'd0;
        res.byte_valid = single;
        res.is_value   = (phase == PH_VALUE);
        res.field_end  = 1'b1;
      end
    end
  end

  // Update parser state on each transfer from the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_OPEN;
      in_string      <= 1'b0;
      escape_pending <= 1'b0;
      token_length   <= 2'd0;
      token_char     <= 8'd0;
    end else if (tok_take) begin
      phase          <= phase_next;
      in_string      <= in_string_next;
      escape_pending <= escape_pending_next;
      token_length   <= token_length_next;
      token_char     <= token_char_next;
    end
  end

  // Store results
  always_ff @(posedge clk) begin
    if (out_wr) begin
      oq[owr_ptr] <= res;
    end
  end

  // Advance result queue pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      owr_ptr <= 1'b0;
      ord_ptr <= 1'b0;
      ocount  <= 2'd0;
    end else begin
      if (out_wr) owr_ptr <= ~owr_ptr;
      if (out_rd) ord_ptr <= ~ord_ptr;
      if (out_wr && !out_rd) begin
        ocount <= ocount + 1'b1;
      end else if (out_rd && !out_wr) begin
        ocount <= ocount - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/flat_json_string_dict_parser_unit.sv
// A byte is registered in the input queue, then its result, if any, in the result queue.
// Throughput: one byte per cycle while the result queue has room or is read; the input
// queue (QUEUE_DEPTH entries) and the two-entry result queue absorb stalls on either side.
// Reset: synchronous, active high; clears both queues and returns the parser to
// expect an opening brace. No clearing pass. Depends on fjsp_pkg, fjsp_front and fjsp_back.
// Top level: wires the classifying front end to the parsing back end.
`timescale 1ns / 1ps
`default_nettype none

module flat_json_string_dict_parser_unit
  import fjsp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire in_item_t item,
  input  wire logic     push,
  output logic          full,
  output result_t       result,
  output logic          empty,
  input  wire logic     pop
);

  tok_t tok;
  logic tok_avail;
  logic tok_take;

  // Classify and queue incoming bytes
  fjsp_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .push      (push),
    .full      (full),
    .tok       (tok),
    .tok_avail (tok_avail),
    .tok_take  (tok_take)
  );

  // Parse and queue results
  fjsp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok       (tok),
    .tok_avail (tok_avail),
    .tok_take  (tok_take),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

`default_nettype wire

FILE: rtl/fjsp_checker.sv
// Port-level checker for the parser, bound to the top level.
// Depends on fjsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fjsp_checker
  import fjsp_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     full,
  input wire result_t  result,
  input wire logic     empty,
  input wire logic     pop
);

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // Reset leaves room for input
  a_reset_room: assert property (@(posedge clk) rst |=> !full)
    else $error("input queue full after reset");

  // A status report carries no character, tag or end mark
  a_report_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status != STATUS_RUN) |->
      (!result.byte_valid && !result.is_value && !result.field_end &&
       result.out_byte == 8'd0))
    else $error("status report carries field data");

  // A running result carries a character or an end mark; an end has one only when single
  a_char_tag: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status == STATUS_RUN) |->
      (result.byte_valid || result.field_end))
    else $error("running result carries neither character nor end mark");

  // A waiting result holds until it is transferred
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed before transfer");

endmodule

bind flat_json_string_dict_parser_unit fjsp_checker u_fjsp_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .result (result),
  .empty  (empty),
  .pop    (pop)
);

`default_nettype wire

FILE: tb/sv/fjsp_result_checker.sv
// Result checker for the flat JSON string dictionary parser: predicts every result and compares.
// Watches the byte and result queues of the unit; depends on fjsp_pkg.
`timescale 1ns / 1ps

module fjsp_result_checker
  import fjsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  in_item_t item,
  input  logic     push,
  input  logic     full,
  input  result_t  result,
  input  logic     empty,
  input  logic     pop,
  output int       mismatch_count,
  output int       outstanding
);

  // Shadow parser state
  phase_t     phase;
  logic       in_str;
  logic       esc_pend;
  logic [1:0] tok_len;
  logic [7:0] tok_chr;

  // Results predicted but not yet transferred, oldest first
  result_t    expected_q[$];

  function automatic void clear_parser();
    phase    = PH_OPEN;
    in_str   = 1'b0;
    esc_pend = 1'b0;
    tok_len  = 2'd0;
    tok_chr  = 8'h00;
  endfunction

  // A structural token is a single character, bare or quoted
  function automatic bit token_is(input logic [7:0] ch);
    return tok_len == 2'd1 && tok_chr == ch;
  endfunction

  // Advance the shadow parser by one byte; returns 1 when the byte yields a result
  function automatic bit parse_byte(input logic [7:0] b, input logic lst, output result_t res);
    bit         field;
    bit         have;
    bit         err;
    bit         done;
    bit         tok_done;
    bit         single;
    bit         add;
    logic [7:0] c;
    res      = '0;
    have     = 1'b0;
    err      = 1'b0;
    done     = 1'b0;
    tok_done = 1'b0;
    single   = 1'b0;
    add      = 1'b0;
    c        = b;
    // Drop bytes after a report until the last one
    if (phase == PH_WAIT) begin
      if (lst) clear_parser();
      return 1'b0;
    end
    field       = (phase == PH_KEY) || (phase == PH_VALUE);
    res.is_value = (phase == PH_VALUE);

    // Decode the byte
    if (in_str) begin
      if (esc_pend) begin
        esc_pend = 1'b0;
        if (b == CH_LET_T) begin
          c   = CH_TAB;
          add = 1'b1;
        end else if (b == CH_LET_N) begin
          c   = CH_NL;
          add = 1'b1;
        end else if (b == CH_BSLASH || b == CH_QUOTE) begin
          add = 1'b1;
        end else begin
          err = 1'b1;
        end
      end else if (b == CH_QUOTE) begin
        in_str   = 1'b0;
        tok_done = 1'b1;
      end else if (b == CH_BSLASH) begin
        esc_pend = 1'b1;
      end else begin
        add = 1'b1;
      end
      if (add) begin
        if (field) begin
          have           = 1'b1;
          res.out_byte   = c;
          res.byte_valid = 1'b1;
        end else begin
          if (tok_len == 2'd0) tok_chr = c;
          if (tok_len < 2'd2) tok_len = tok_len + 2'd1;
        end
      end
    end else if (b == CH_SPACE) begin
      // skip
    end else if (b == CH_QUOTE) begin
      in_str   = 1'b1;
      esc_pend = 1'b0;
      tok_len  = 2'd0;
      tok_chr  = 8'h00;
    end else begin
      tok_len  = 2'd1;
      tok_chr  = b;
      tok_done = 1'b1;
      single   = 1'b1;
    end

    // Act on a completed token
    if (tok_done) begin
      case (phase) inside
        PH_OPEN: begin
          if (token_is(CH_OPEN)) phase = PH_KEY;
          else err = 1'b1;
        end
        PH_KEY, PH_VALUE: begin
          have          = 1'b1;
          res.field_end = 1'b1;
          if (single) begin
            res.out_byte   = b;
            res.byte_valid = 1'b1;
          end
          phase = (phase == PH_KEY) ? PH_COLON : PH_SEP;
        end
        PH_COLON: begin
          if (token_is(CH_COLON)) phase = PH_VALUE;
          else err = 1'b1;
        end
        default: begin
          if (token_is(CH_COMMA)) phase = PH_KEY;
          else if (token_is(CH_CLOSE)) done = 1'b1;
          else err = 1'b1;
        end
      endcase
    end

    if (!err && !done && lst) err = 1'b1;

    // A report replaces any character result
    if (err || done) begin
      res        = '0;
      res.status = err ? STATUS_ERROR : STATUS_DONE;
      if (lst) begin
        clear_parser();
      end else begin
        phase    = PH_WAIT;
        in_str   = 1'b0;
        esc_pend = 1'b0;
      end
      return 1'b1;
    end
    return have;
  endfunction

  function automatic string fmt_result(input result_t r);
    return $sformatf("byte %02h valid %0d value %0d end %0d status %0d",
                     r.out_byte, r.byte_valid, r.is_value, r.field_end, r.status);
  endfunction

  function automatic void report_result(input string what, input result_t want,
                                        input result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%t %s: expected %s, got %s", $realtime, what,
               fmt_result(want), fmt_result(got));
  endfunction

  // Check each result transfer, then predict from each byte transfer
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_parser();
      expected_q.delete();
      mismatch_count = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          report_result("unexpected result", '0, result);
        end else begin
          want = expected_q.pop_front();
          if (result.out_byte !== want.out_byte || result.byte_valid !== want.byte_valid ||
              result.is_value !== want.is_value || result.field_end !== want.field_end ||
              result.status !== want.status)
            report_result("result mismatch", want, result);
        end
      end
      if (push && !full) begin
        if (parse_byte(item.in_byte, item.last_byte, want)) expected_q.push_back(want);
      end
    end
    outstanding <= expected_q.size();
  end

endmodule

FILE: tb/sv/flat_json_string_dict_parser_unit_tb.sv
// Testbench top for the flat JSON string dictionary parser: byte stimulus, result drain, verdict.
// Depends on fjsp_pkg, flat_json_string_dict_parser_unit and fjsp_result_checker.
`timescale 1ns / 1ps

module flat_json_string_dict_parser_unit_tb;
  import fjsp_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_BYTES = 2000;
  localparam int HOLD_CYCLES  = 80;

  logic       clk  = 1'b0;
  logic       rst  = 1'b1;
  in_item_t   item = '0;
  logic       push = 1'b0;
  logic       pop  = 1'b0;
  logic       full;
  logic       empty;
  result_t    result;
  int         mismatch_count;
  int         outstanding;
  int         quiet_cycles = 0;
  bit         no_idle = 1'b0;
  logic [7:0] doc_text[$];

  always #1 clk = ~clk;

  flat_json_string_dict_parser_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .push   (push),
    .full   (full),
    .result (result),
    .empty  (empty),
    .pop    (pop)
  );

  fjsp_result_checker u_result_check (
    .clk            (clk),
    .rst            (rst),
    .item           (item),
    .push           (push),
    .full           (full),
    .result         (result),
    .empty          (empty),
    .pop            (pop),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  function automatic int idle_draw();
    return no_idle ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic void load_text(input string s);
    doc_text.delete();
    for (int i = 0; i < s.len(); i++) doc_text.push_back(s[i]);
  endfunction

  // Document building blocks
  function automatic void pad_spaces();
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) doc_text.push_back(CH_SPACE);
  endfunction

  function automatic void add_struct(input logic [7:0] ch);
    pad_spaces();
    if ($urandom_range(0, 7) == 0) begin
      doc_text.push_back(CH_QUOTE);
      doc_text.push_back(ch);
      doc_text.push_back(CH_QUOTE);
    end else begin
      doc_text.push_back(ch);
    end
  endfunction

  function automatic void add_field();
    logic [7:0] c;
    pad_spaces();
    if ($urandom_range(0, 2) == 0) begin
      do c = 8'($urandom_range(0, 255)); while (c == CH_SPACE || c == CH_QUOTE);
      doc_text.push_back(c);
    end else begin
      doc_text.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 5)) begin
        c = 8'($urandom_range(0, 255));
        if (c == CH_QUOTE || c == CH_BSLASH || $urandom_range(0, 5) == 0) begin
          doc_text.push_back(CH_BSLASH);
          case ($urandom_range(0, 3))
            0:       doc_text.push_back(CH_LET_T);
            1:       doc_text.push_back(CH_LET_N);
            2:       doc_text.push_back(CH_BSLASH);
            default: doc_text.push_back(CH_QUOTE);
          endcase
        end else begin
          doc_text.push_back(c);
        end
      end
      doc_text.push_back(CH_QUOTE);
    end
  endfunction

  // Mostly well-formed objects; some corrupted, cut short or pure noise
  function automatic void build_random_doc();
    int         kind;
    int         pairs;
    int         pos;
    logic [7:0] c;
    kind = $urandom_range(0, 19);
    doc_text.delete();
    if (kind == 19) begin
      repeat ($urandom_range(1, 8)) doc_text.push_back(8'($urandom_range(0, 255)));
      return;
    end
    add_struct(CH_OPEN);
    pairs = $urandom_range(1, 4);
    for (int p = 0; p < pairs; p++) begin
      add_field();
      add_struct(CH_COLON);
      add_field();
      add_struct((p == pairs - 1) ? CH_CLOSE : CH_COMMA);
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) doc_text.push_back(8'($urandom_range(0, 255)));
    if (kind >= 14 && kind <= 16) begin
      pos = $urandom_range(0, doc_text.size() - 1);
      case ($urandom_range(0, 5))
        0:       c = CH_OPEN;
        1:       c = CH_COLON;
        2:       c = CH_COMMA;
        3:       c = CH_QUOTE;
        4:       c = CH_BSLASH;
        default: c = 8'($urandom_range(0, 255));
      endcase
      doc_text[pos] = c;
    end else if (kind >= 17) begin
      pos = $urandom_range(1, doc_text.size() - 1);
      doc_text = doc_text[0:pos-1];
    end
  endfunction

  // Offer one byte after a random gap and hold it until transferred
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= '{in_byte: b, last_byte: lst};
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_doc();
    int n;
    n = doc_text.size();
    for (int i = 0; i < n; i++) send_byte(doc_text[i], i == n - 1);
  endtask

  // Byte stimulus and verdict
  initial begin
    int random_sent;
    random_sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Every escape, quoted key and value, done on the last byte
    load_text("{\"\\n\\t\":\"\\\\\\\"\"}");
    send_doc();
    // Field extremes; document ends early, right after a value
    doc_text = '{CH_OPEN, 8'hFF, CH_COLON, 8'h00};
    send_doc();
    // Bad escape, then wait for the last byte
    load_text("{\"\\q ");
    send_doc();
    // Quoted structural token that is too long
    load_text("\"::\"");
    send_doc();

    while (random_sent < RANDOM_BYTES) begin
      no_idle = ($urandom_range(0, 3) == 0);
      build_random_doc();
      random_sent += doc_text.size();
      send_doc();
    end
    push <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Result drain with random stalls and two long hold-offs
  initial begin
    int wait_cycles;
    int taken;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      wait_cycles = (taken == 150 || taken == 700) ? HOLD_CYCLES : idle_draw();
      if (wait_cycles > 0) begin
        pop <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      taken++;
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

FILE: filelist.f
rtl/fjsp_pkg.sv
rtl/fjsp_front.sv
rtl/fjsp_back.sv
rtl/flat_json_string_dict_parser_unit.sv
rtl/fjsp_checker.sv
tb/sv/fjsp_result_checker.sv
tb/sv/flat_json_string_dict_parser_unit_tb.sv
